// File: sv/sltt_pkg.sv
// Package for the sorted list table: sizes, command and status codes,
// word types for the two channels and the cell control/flag structs.
// No dependencies.
package sltt_pkg;

    // table geometry
    localparam int DEPTH  = 16;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = 4;
    localparam int DATA_W = 32;

    // command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    // input word
    typedef struct packed {
        logic [1:0]               cmd;
        logic signed [DATA_W-1:0] value;
        logic [IDX_W-1:0]         index;
    } t_in;

    // result word
    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] read_value;
        logic [CNT_W-1:0]         count;
    } t_out;

    // broadcast to every cell
    typedef struct packed {
        logic                     ins;    // insert committed this cycle
        logic                     rem;    // remove committed, value present
        logic signed [DATA_W-1:0] value;
    } t_cell_ctl;

    // compare results of one cell against the broadcast value
    typedef struct packed {
        logic le;   // held and entry <= value
        logic lt;   // held and entry <  value
        logic eq;   // held and entry == value
    } t_cell_flg;

endpackage

// File: sv/sltt_cell.sv
// One cell of the sorted table: holds a single entry, compares it with the
// broadcast value and shifts from a neighbour on insert or remove.
// Depends on sltt_pkg.
module sltt_cell
    import sltt_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_valid,     // this position is below the count
    input  logic                     i_left_le,   // left cell's le flag (1 for cell 0)
    input  logic signed [DATA_W-1:0] i_left_word,
    input  logic signed [DATA_W-1:0] i_right_word,
    input  t_cell_ctl                i_ctl,
    output logic signed [DATA_W-1:0] o_word,
    output t_cell_flg                o_flg
);

    logic signed [DATA_W-1:0] r_word;
    logic signed [DATA_W-1:0] n_word;

    // compare against the broadcast value
    always_comb begin
        o_flg.le = i_valid && (r_word <= i_ctl.value);
        o_flg.lt = i_valid && (r_word <  i_ctl.value);
        o_flg.eq = i_valid && (r_word == i_ctl.value);
    end

    // insert: cells past the insertion point shift right, the first takes
    // the value; remove: cells from the first match onward shift left
    always_comb begin
        n_word = r_word;
        if (i_ctl.ins && !o_flg.le) begin
            n_word = i_left_le ? i_ctl.value : i_left_word;
        end else if (i_ctl.rem && !o_flg.lt) begin
            n_word = i_right_word;
        end
    end

    // payload only, no reset
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

// File: sv/sorted_list_table_top.sv
// Top level of the sorted list table: a row of sltt_cell, the entry count,
// the read mux and the result register.
// Depends on sltt_pkg and sltt_cell.
//
//  channel | valid       | ready       | word
//  --------+-------------+-------------+----------------------------
//  input   | i_in_valid  | o_in_ready  | i_in  (cmd, value, index)
//  result  | o_out_valid | i_out_ready | o_out (status, read_value, count)
//
// The cells compare and shift in the cycle of acceptance, and the result
// appears in the output register next cycle. One word per cycle is
// sustained while results are taken; the single result register sets that
// figure. A word is accepted while a result is being taken in the same
// cycle. Synchronous active-low reset empties the table (count zero) and
// the result register; entry contents are not cleared.
module sorted_list_table_top
    import sltt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_out             r_out;
    t_out             n_out;

    logic                     accept;
    logic                     full;
    logic                     found;
    t_cell_ctl                ctl;
    logic signed [DATA_W-1:0] words [DEPTH];
    t_cell_flg                flgs  [DEPTH];
    logic [DEPTH-1:0]         eq_vec;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign full       = (r_count == CNT_W'(DEPTH));

    // any held entry equal to the value
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            eq_vec[k] = flgs[k].eq;
        end
    end
    assign found = |eq_vec;

    // broadcast control
    always_comb begin
        ctl.value = i_in.value;
        ctl.ins   = accept && (i_in.cmd == CMD_INSERT) && !full;
        ctl.rem   = accept && (i_in.cmd == CMD_REMOVE) && found;
    end

    // row of cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                     left_le;
        logic signed [DATA_W-1:0] left_word;
        logic signed [DATA_W-1:0] right_word;

        if (g == 0) begin : g_first
            assign left_le   = 1'b1;
            assign left_word = words[0];
        end else begin : g_mid
            assign left_le   = flgs[g-1].le;
            assign left_word = words[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_word = words[g];
        end else begin : g_inner
            assign right_word = words[g+1];
        end

        sltt_cell u_cell (
            .i_clk        (i_clk),
            .i_valid      (r_count > CNT_W'(g)),
            .i_left_le    (left_le),
            .i_left_word  (left_word),
            .i_right_word (right_word),
            .i_ctl        (ctl),
            .o_word       (words[g]),
            .o_flg        (flgs[g])
        );
    end

    // count after the operation and the result word
    always_comb begin
        n_count          = r_count;
        n_out.status     = ST_OK;
        n_out.read_value = '0;
        if (ctl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (ctl.rem) begin
            n_count = r_count - CNT_W'(1);
        end
        unique case (i_in.cmd)
            CMD_INSERT: begin
                if (full) begin
                    n_out.status = ST_FULL;
                end
            end
            CMD_REMOVE: begin
                if (!found) begin
                    n_out.status = ST_NOT_FOUND;
                end
            end
            CMD_READ: begin
                if (CNT_W'(i_in.index) >= r_count) begin
                    n_out.status = ST_RANGE;
                end else begin
                    n_out.read_value = words[i_in.index];
                end
            end
            default: begin
                n_out.status = ST_OK;
            end
        endcase
        n_out.count = n_count;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: sv/sltt_chk.sv
// Port-level checker for the sorted list table, bound to the top level.
// Depends on sltt_pkg and sorted_list_table_top.
module sltt_chk
    import sltt_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("result word changed while stalled");

    // count never exceeds the table depth
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.count <= CNT_W'(DEPTH)))
        else $error("count beyond table depth");

    // errors carry a zero read value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.status != ST_OK)) |-> (o_out.read_value == '0))
        else $error("read value nonzero on error");

    // reset empties the result register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // an accepted word always produces a result next cycle
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("accepted word gave no result");

endmodule

bind sorted_list_table_top sltt_chk u_sltt_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
